// ----- rtl/core/bdac_pkg.sv -----
package bdac_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int DIGIT_COUNT = 10;
   localparam int NIBBLE_WIDTH = 4;
   localparam int BCD_WIDTH = DIGIT_COUNT * NIBBLE_WIDTH;
   localparam int STEP_WIDTH = $clog2(VALUE_WIDTH);
   localparam int IDX_WIDTH = $clog2(DIGIT_COUNT);
   localparam int CHAR_WIDTH = 6;

   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 6'd48;

   typedef logic [BCD_WIDTH-1:0] bcd_type;

endpackage

// ----- rtl/core/bdac_dabble.sv -----
module bdac_dabble
   import bdac_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic [VALUE_WIDTH-1:0] load_value,
   output logic                   busy,
   output logic                   done,
   output bcd_type                bcd
);

   logic                   run_ff, run_in;
   logic                   done_ff, done_in;
   logic [STEP_WIDTH-1:0]  count_ff, count_in;
   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   bcd_type                bcd_ff, bcd_in;
   bcd_type                adjusted;

   always_comb begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         if (bcd_ff[i*NIBBLE_WIDTH +: NIBBLE_WIDTH] >= 4'd5) begin
            adjusted[i*NIBBLE_WIDTH +: NIBBLE_WIDTH] =
               bcd_ff[i*NIBBLE_WIDTH +: NIBBLE_WIDTH] + 4'd3;
         end else begin
            adjusted[i*NIBBLE_WIDTH +: NIBBLE_WIDTH] =
               bcd_ff[i*NIBBLE_WIDTH +: NIBBLE_WIDTH];
         end
      end
   end

   always_comb begin
      run_in   = run_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      if (load) begin
         run_in   = 1'b1;
         count_in = '0;
         bin_in   = load_value;
         bcd_in   = '0;
      end else if (run_ff) begin
         bcd_in   = {adjusted[BCD_WIDTH-2:0], bin_ff[VALUE_WIDTH-1]};
         bin_in   = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
         count_in = count_ff + 1'b1;
         if (count_ff == STEP_WIDTH'(VALUE_WIDTH - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         run_ff   <= run_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign busy = run_ff | done_ff;
   assign done = done_ff;
   assign bcd  = bcd_ff;

`ifndef NO_ASSERTIONS
   a_done_after_last_step: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(run_ff) && $past(count_ff) == STEP_WIDTH'(VALUE_WIDTH - 1))
      else $error("done without a full pass of shift steps");
`endif

endmodule

// ----- rtl/core/bdac_emit.sv -----
module bdac_emit
   import bdac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  bcd_type               load_bcd,
   output logic                  busy,
   output logic                  strobe,
   output logic [CHAR_WIDTH-1:0] digit_char,
   output logic                  last_digit
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SKIP = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]              state_ff, state_in;
   bcd_type                 digits_ff, digits_in;
   logic [IDX_WIDTH-1:0]    idx_ff, idx_in;
   logic                    strobe_ff, strobe_in;
   logic [CHAR_WIDTH-1:0]   char_ff, char_in;
   logic                    last_ff, last_in;
   logic [NIBBLE_WIDTH-1:0] top_nibble;

   assign top_nibble = digits_ff[BCD_WIDTH-1 -: NIBBLE_WIDTH];

   always_comb begin
      state_in  = state_ff;
      digits_in = digits_ff;
      idx_in    = idx_ff;
      strobe_in = 1'b0;
      char_in   = char_ff;
      last_in   = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (load) begin
               digits_in = load_bcd;
               idx_in    = IDX_WIDTH'(DIGIT_COUNT - 1);
               state_in  = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (top_nibble == '0 && idx_ff != '0) begin
               digits_in = {digits_ff[BCD_WIDTH-NIBBLE_WIDTH-1:0], {NIBBLE_WIDTH{1'b0}}};
               idx_in    = idx_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            strobe_in = 1'b1;
            char_in   = ASCII_ZERO + CHAR_WIDTH'(top_nibble);
            last_in   = (idx_ff == '0);
            digits_in = {digits_ff[BCD_WIDTH-NIBBLE_WIDTH-1:0], {NIBBLE_WIDTH{1'b0}}};
            if (idx_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      digits_ff <= digits_in;
      idx_ff    <= idx_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign strobe     = strobe_ff;
   assign digit_char = char_ff;
   assign last_digit = last_ff;

`ifndef NO_ASSERTIONS
   a_strobe_from_emit: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> $past(state_ff) == ST_EMIT)
      else $error("result word without an emit step");

   a_load_when_idle: assert property (@(posedge clock) disable iff (reset)
      load |-> state_ff == ST_IDLE)
      else $error("digit register loaded while a run is in flight");
`endif

endmodule

// ----- rtl/core/binary_to_decimal_ascii_core.sv -----
// Channel   Ports                                   Handshake
// request   req_value                               start while busy low
// result    rsp_digit_char, rsp_last_digit          rsp_strobe, one cycle
//
// A value goes from the accepting edge to busy low through one shift-and-adjust pass
// of the BCD register per input bit, a handoff through the done register and a
// ten-position scan of the digit register, which skips leading zeros and
// then sends one digit word a cycle.
// Synchronous active-high reset clears the sequencers; payload is not reset.
// The receiver cannot stall: each word is valid for exactly one cycle.
module binary_to_decimal_ascii_core
   import bdac_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_strobe,
   output logic [CHAR_WIDTH-1:0]  rsp_digit_char,
   output logic                   rsp_last_digit
);

   logic    accept;
   logic    dabble_busy;
   logic    dabble_done;
   logic    emit_busy;
   bcd_type bcd;

   assign busy   = dabble_busy | emit_busy;
   assign accept = start & ~busy;

   bdac_dabble u_dabble (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .load_value (req_value),
      .busy       (dabble_busy),
      .done       (dabble_done),
      .bcd        (bcd)
   );

   bdac_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (dabble_done),
      .load_bcd   (bcd),
      .busy       (emit_busy),
      .strobe     (rsp_strobe),
      .digit_char (rsp_digit_char),
      .last_digit (rsp_last_digit)
   );

`ifndef NO_ASSERTIONS
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(dabble_busy && emit_busy))
      else $error("conversion and digit output active together");

   a_run_ends_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_digit |=> !rsp_strobe)
      else $error("word sent after the last digit");
`endif

endmodule

// ----- tb/binary_to_decimal_ascii_core_tb.sv -----
module binary_to_decimal_ascii_core_tb;
   import bdac_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DECIMAL_RADIX = 10;
   localparam int MISMATCH_REPORTS = 10;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] ch;
      logic                  last;
   } digit_word_type;

   class digit_scoreboard;
      digit_word_type pending_digits[$];
      int unsigned fail_count;

      function new();
         fail_count = 0;
      endfunction

      function int pending();
         return pending_digits.size();
      endfunction

      function void note_value(input logic [VALUE_WIDTH-1:0] value);
         logic [VALUE_WIDTH-1:0] rest;
         logic [NIBBLE_WIDTH-1:0] digits[DIGIT_COUNT];
         int count;
         digit_word_type w;
         rest = value;
         count = 0;
         do begin
            digits[count] = NIBBLE_WIDTH'(rest % DECIMAL_RADIX);
            rest = rest / DECIMAL_RADIX;
            count++;
         end while (rest != 0 && count < DIGIT_COUNT);
         for (int k = count - 1; k >= 0; k--) begin
            w.ch = ASCII_ZERO + CHAR_WIDTH'(digits[k]);
            w.last = (k == 0);
            pending_digits.push_back(w);
         end
      endfunction

      function void note_failure(input string msg);
         fail_count++;
         if (fail_count <= MISMATCH_REPORTS) $display("%0t: %s", $realtime, msg);
      endfunction

      function void check_digit(input logic [CHAR_WIDTH-1:0] ch, input logic last);
         digit_word_type want;
         if (pending_digits.size() == 0) begin
            note_failure($sformatf("unexpected digit word: char %0d last %0b", ch, last));
            return;
         end
         want = pending_digits.pop_front();
         if (ch !== want.ch || last !== want.last)
            note_failure($sformatf("digit mismatch: expected char %0d last %0b, got char %0d last %0b",
                                   want.ch, want.last, ch, last));
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [VALUE_WIDTH-1:0] req_value;
   logic                   rsp_strobe;
   logic [CHAR_WIDTH-1:0]  rsp_digit_char;
   logic                   rsp_last_digit;

   digit_scoreboard sb;

   logic [VALUE_WIDTH-1:0] corner_values [18] = '{
      32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd4294967295, 32'd4294967294,
      32'd1000000000, 32'd999999999, 32'd2147483648, 32'd2147483647, 32'd12345,
      32'hAAAAAAAA, 32'h55555555, 32'd4000000000, 32'd1234567890, 32'd7
   };

   binary_to_decimal_ascii_core dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) sb.check_digit(rsp_digit_char, rsp_last_digit);
         if (start && !busy) sb.note_value(req_value);
      end
   end

   task automatic send_value(input logic [VALUE_WIDTH-1:0] value, input int idle_pct);
      while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         req_value <= $urandom;
         @(posedge clock);
      end
      start <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic run_random(input int count, input int idle_pct, input bit drain_midway);
      logic [VALUE_WIDTH-1:0] value;
      logic [VALUE_WIDTH-1:0] scale;
      for (int i = 0; i < count; i++) begin
         if (drain_midway && i == count / 2) begin
            start <= 1'b0;
            do @(posedge clock); while (sb.pending() != 0);
         end
         if ($urandom_range(3, 0) == 0) begin
            scale = 1;
            repeat ($urandom_range(9, 1)) scale = scale * DECIMAL_RADIX;
            value = scale - $urandom_range(1, 0);
         end else begin
            value = $urandom >> $urandom_range(VALUE_WIDTH - 1, 0);
         end
         send_value(value, idle_pct);
      end
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      start = 1'b0;
      req_value = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (corner_values[i]) send_value(corner_values[i], 0);
      run_random(28, 33, 1'b0);
      run_random(27, 46, 1'b1);
      run_random(27, 0, 1'b0);
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.fail_count == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
